// ===== rtl/core/sca_pkg.sv =====
package sca_pkg;

   localparam int NUM_PAGES_DEFAULT = 64;
   localparam int PAGE_BYTES        = 4096;
   localparam int CLASS_COUNT       = 7;
   localparam int MAP_W             = 64;
   localparam int WORD_W            = MAP_W + 3;
   localparam int SIZE_W            = 13;
   localparam int OFFSET_W          = 18;
   localparam int COUNT_W           = 7;
   localparam int PAGE_COUNT_RESET  = 64;

   localparam logic [2:0] EMPTY_CLASS = 3'd7;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_PAGE_COUNT = 1'b0;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_PAGES    = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE   = 2'd2;
   localparam logic [1:0] ST_FREE_IGNORE = 2'd3;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_ALLOC,
      FSM_FREE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   function automatic logic [2:0] size_class(input logic [SIZE_W-1:0] size);
      logic [2:0] c;
      if (size <= 13'd64) c = 3'd0;
      else if (size <= 13'd128) c = 3'd1;
      else if (size <= 13'd256) c = 3'd2;
      else if (size <= 13'd512) c = 3'd3;
      else if (size <= 13'd1024) c = 3'd4;
      else if (size <= 13'd2048) c = 3'd5;
      else c = 3'd6;
      return c;
   endfunction

   function automatic logic [MAP_W-1:0] full_mask(input logic [2:0] c);
      logic [MAP_W-1:0] m;
      unique case (c)
         3'd0: m = {64{1'b1}};
         3'd1: m = {32'd0, {32{1'b1}}};
         3'd2: m = {48'd0, {16{1'b1}}};
         3'd3: m = {56'd0, 8'hFF};
         3'd4: m = {60'd0, 4'hF};
         3'd5: m = {62'd0, 2'h3};
         3'd6: m = {63'd0, 1'b1};
         default: m = '0;
      endcase
      return m;
   endfunction

   // Bit 6 flags that a clear slot exists; bits 5:0 give the lowest one.
   function automatic logic [6:0] lowest_zero(input logic [MAP_W-1:0] map,
                                              input logic [2:0] c);
      logic [MAP_W-1:0] avail;
      logic [5:0] idx;
      avail = ~map & full_mask(c);
      idx = '0;
      for (int k = MAP_W - 1; k >= 0; k--) begin
         if (avail[k]) idx = 6'(k);
      end
      return {|avail, idx};
   endfunction

endpackage

// ===== rtl/core/sca_if.sv =====
interface sca_req_if import sca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SIZE_W-1:0]   alloc_size;
   logic [OFFSET_W-1:0] free_offset;

   modport source (output valid, cmd, alloc_size, free_offset, input ready);
   modport sink (input valid, cmd, alloc_size, free_offset, output ready);
endinterface

interface sca_rsp_if import sca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] address;
   logic [1:0]          status;

   modport source (output valid, address, status, input ready);
   modport sink (input valid, address, status, output ready);
endinterface

// ===== rtl/core/slab_size_class_allocator.sv =====
// Channel   Dir  Beat fields                          Handshake
// req       in   cmd, alloc_size, free_offset         valid/ready
// rsp       out  address, status                      valid/ready
// csr       in   APB page_count at byte address 0     psel/penable, pready high
//
// One request is worked on at a time: a rejected allocate or an out-of-pool free goes from IDLE
// straight to DONE; any other passes through ALLOC or FREE, plus a forward scan when a page fills,
// is claimed, or empties while it is its class's open page; claiming a page that then fills runs
// two scans. After reset and after each page_count write a clearing pass rewrites all NUM_PAGES
// words of the page memory; no request is taken meanwhile. An untaken result stalls the next one
// in DONE; a taken or empty output register lets the block return to IDLE for the next beat.
module slab_size_class_allocator import sca_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   sca_req_if.sink       req,
   sca_rsp_if.source     rsp,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PW = $clog2(NUM_PAGES + 1);
   localparam int LW = (PW > COUNT_W) ? PW : COUNT_W;
   localparam logic [LW-1:0] POOL_RESET =
      LW'((NUM_PAGES < PAGE_COUNT_RESET) ? NUM_PAGES : PAGE_COUNT_RESET);
   localparam logic [LW-1:0] NUM_PAGES_W = LW'(NUM_PAGES);

   fsm_type state_ff, state_in;

   logic [COUNT_W-1:0]  page_count_ff, page_count_in;
   logic [LW-1:0]       first_empty_ff, first_empty_in;
   logic [LW-1:0]       class_free_ff [CLASS_COUNT];
   logic [LW-1:0]       class_free_in [CLASS_COUNT];
   logic [AW-1:0]       clr_ff, clr_in;
   logic [2:0]          class_ff, class_in;
   logic [LW-1:0]       page_ff, page_in;
   logic                claim_ff, claim_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [OFFSET_W-1:0] res_addr_ff, res_addr_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                pend_open_ff, pend_open_in;
   logic                scan_open_ff, scan_open_in;
   logic [LW-1:0]       scan_next_ff, scan_next_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [LW-1:0]       chk_addr_ff, chk_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_address_ff, rsp_address_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic [AW-1:0]       mem_raddr;
   logic [WORD_W-1:0]   mem_rdata;

   logic                cfg_we;
   logic [LW-1:0]       pc_ext, lim_w, new_pc_ext, new_lim;
   logic                accept;
   logic [2:0]          req_c;
   logic [LW-1:0]       req_page;
   logic [2:0]          rd_class;
   logic [MAP_W-1:0]    rd_map;
   logic [2:0]          cf_idx;
   logic [LW-1:0]       cf_cur;
   logic [MAP_W-1:0]    a_map, a_new;
   logic [6:0]          a_lz;
   logic                a_full;
   logic [11:0]         a_slot;
   logic [5:0]          f_idx;
   logic [MAP_W-1:0]    f_new;
   logic                scan_match, scan_end;
   logic [LW-1:0]       scan_found;

   sca_ram #(.WIDTH(WORD_W), .DEPTH(NUM_PAGES)) u_page_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_PAGE_COUNT) ? {25'd0, page_count_ff} : 32'd0;
   assign cfg_we = psel && penable && pwrite;

   assign pc_ext     = LW'(page_count_ff);
   assign lim_w      = (pc_ext > NUM_PAGES_W) ? NUM_PAGES_W : pc_ext;
   assign new_pc_ext = LW'(pwdata[COUNT_W-1:0]);
   assign new_lim    = (new_pc_ext > NUM_PAGES_W) ? NUM_PAGES_W : new_pc_ext;

   assign req.ready   = (state_ff == FSM_IDLE);
   assign accept      = req.valid && req.ready;
   assign req_c       = size_class(req.alloc_size);
   assign req_page    = LW'(req.free_offset[OFFSET_W-1:12]);

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.address = rsp_address_ff;
   assign rsp.status  = rsp_status_ff;

   assign rd_class = mem_rdata[WORD_W-1:MAP_W];
   assign rd_map   = mem_rdata[MAP_W-1:0];

   always_comb begin
      unique case (state_ff)
         FSM_IDLE: cf_idx = req_c;
         FSM_FREE: cf_idx = (rd_class == EMPTY_CLASS) ? 3'd0 : rd_class;
         default:  cf_idx = class_ff;
      endcase
   end
   assign cf_cur = class_free_ff[cf_idx];

   assign a_map  = claim_ff ? '0 : rd_map;
   assign a_lz   = lowest_zero(a_map, class_ff);
   assign a_new  = a_map | (64'd1 << a_lz[5:0]);
   assign a_full = (a_new == full_mask(class_ff));
   assign a_slot = 12'(12'(a_lz[5:0]) << (4'd6 + 4'(class_ff)));

   assign f_idx  = 6'(offset_ff[11:0] >> (4'd6 + 4'(rd_class)));
   assign f_new  = rd_map & ~(64'd1 << f_idx);

   assign scan_match = scan_open_ff
                     ? (rd_class == class_ff) && (rd_map != full_mask(class_ff))
                     : (rd_class == EMPTY_CLASS);
   assign scan_end   = (chk_valid_ff && scan_match) || (scan_next_ff >= lim_w);
   assign scan_found = (chk_valid_ff && scan_match) ? chk_addr_ff : lim_w;

   always_comb begin
      state_in = state_ff;
      priority if (cfg_we && paddr[2] == REG_PAGE_COUNT) begin
         state_in = FSM_CLEAR;
      end else begin
         unique case (state_ff)
            FSM_CLEAR: begin
               if (clr_ff == AW'(NUM_PAGES - 1)) state_in = FSM_IDLE;
            end
            FSM_IDLE: begin
               if (accept) begin
                  if (req.cmd == CMD_ALLOC) begin
                     if (req.alloc_size > 13'(PAGE_BYTES)) state_in = FSM_DONE;
                     else if (cf_cur < lim_w || first_empty_ff < lim_w) state_in = FSM_ALLOC;
                     else state_in = FSM_DONE;
                  end else begin
                     state_in = (req_page >= lim_w) ? FSM_DONE : FSM_FREE;
                  end
               end
            end
            FSM_ALLOC: begin
               state_in = (a_lz[6] && (claim_ff || a_full)) ? FSM_SCAN : FSM_DONE;
            end
            FSM_FREE: begin
               state_in = (rd_class != EMPTY_CLASS && f_new == '0 && cf_cur == page_ff)
                        ? FSM_SCAN : FSM_DONE;
            end
            FSM_SCAN: begin
               if (scan_end && (scan_open_ff || !pend_open_ff)) state_in = FSM_DONE;
            end
            FSM_DONE: begin
               if (!rsp_valid_ff || rsp.ready) state_in = FSM_IDLE;
            end
            default: state_in = FSM_IDLE;
         endcase
      end
   end

   always_comb begin
      page_count_in  = page_count_ff;
      first_empty_in = first_empty_ff;
      class_free_in  = class_free_ff;
      clr_in         = clr_ff;
      class_in       = class_ff;
      page_in        = page_ff;
      claim_in       = claim_ff;
      offset_in      = offset_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      pend_open_in   = pend_open_ff;
      scan_open_in   = scan_open_ff;
      scan_next_in   = scan_next_ff;
      chk_valid_in   = chk_valid_ff;
      chk_addr_in    = chk_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = page_ff[AW-1:0];
      mem_wdata      = {EMPTY_CLASS, {MAP_W{1'b0}}};
      mem_raddr      = scan_next_ff[AW-1:0];

      unique case (state_ff)
         FSM_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
         end
         FSM_IDLE: begin
            mem_raddr = req_page[AW-1:0];
            if (accept) begin
               offset_in     = req.free_offset;
               class_in      = req_c;
               page_in       = req_page;
               claim_in      = 1'b0;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               if (req.cmd == CMD_ALLOC) begin
                  if (req.alloc_size > 13'(PAGE_BYTES)) begin
                     res_status_in = ST_TOO_LARGE;
                  end else if (cf_cur < lim_w) begin
                     page_in   = cf_cur;
                     mem_raddr = cf_cur[AW-1:0];
                  end else if (first_empty_ff < lim_w) begin
                     page_in              = first_empty_ff;
                     claim_in             = 1'b1;
                     class_free_in[req_c] = first_empty_ff;
                  end else begin
                     res_status_in = ST_NO_PAGES;
                  end
               end else if (req_page >= lim_w) begin
                  res_status_in = ST_FREE_IGNORE;
               end
            end
         end
         FSM_ALLOC: begin
            if (a_lz[6]) begin
               mem_we       = 1'b1;
               mem_wdata    = {class_ff, a_new};
               res_addr_in  = {page_ff[5:0], a_slot};
               pend_open_in = a_full;
               scan_open_in = !claim_ff;
               scan_next_in = page_ff + 1'b1;
               chk_valid_in = 1'b0;
            end else begin
               res_status_in = ST_NO_PAGES;
            end
         end
         FSM_FREE: begin
            if (rd_class == EMPTY_CLASS) begin
               res_status_in = ST_FREE_IGNORE;
            end else begin
               mem_we   = 1'b1;
               class_in = rd_class;
               if (f_new == '0) begin
                  if (page_ff < first_empty_ff) first_empty_in = page_ff;
                  scan_open_in = 1'b1;
                  pend_open_in = 1'b0;
                  scan_next_in = page_ff + 1'b1;
                  chk_valid_in = 1'b0;
               end else begin
                  mem_wdata = {rd_class, f_new};
                  if (page_ff < cf_cur) class_free_in[cf_idx] = page_ff;
               end
            end
         end
         FSM_SCAN: begin
            if (scan_end) begin
               if (scan_open_ff) begin
                  class_free_in[class_ff] = scan_found;
               end else begin
                  first_empty_in = scan_found;
                  scan_open_in   = 1'b1;
                  pend_open_in   = 1'b0;
                  scan_next_in   = page_ff + 1'b1;
                  chk_valid_in   = 1'b0;
               end
            end else begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_next_ff;
               scan_next_in = scan_next_ff + 1'b1;
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
            end
         end
         default: ;
      endcase

      if (cfg_we && paddr[2] == REG_PAGE_COUNT) begin
         page_count_in  = pwdata[COUNT_W-1:0];
         first_empty_in = '0;
         clr_in         = '0;
         for (int c = 0; c < CLASS_COUNT; c++) class_free_in[c] = new_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_CLEAR;
         page_count_ff  <= COUNT_W'(PAGE_COUNT_RESET);
         first_empty_ff <= '0;
         for (int c = 0; c < CLASS_COUNT; c++) class_free_ff[c] <= POOL_RESET;
         clr_ff         <= '0;
         chk_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         page_count_ff  <= page_count_in;
         first_empty_ff <= first_empty_in;
         class_free_ff  <= class_free_in;
         clr_ff         <= clr_in;
         chk_valid_ff   <= chk_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff       <= class_in;
      page_ff        <= page_in;
      claim_ff       <= claim_in;
      offset_ff      <= offset_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      pend_open_ff   <= pend_open_in;
      scan_open_ff   <= scan_open_in;
      scan_next_ff   <= scan_next_in;
      chk_addr_ff    <= chk_addr_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_CLEAR |-> !req.ready)
      else $error("request taken during the clearing pass");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !cfg_we |=> state_ff != FSM_IDLE)
      else $error("accepted beat did not start work");

   a_first_empty_bound: assert property (@(posedge clock) disable iff (reset)
      first_empty_ff <= lim_w)
      else $error("empty page pointer beyond the pool");

endmodule

// ===== rtl/core/sca_ram.sv =====
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
